### hw/rtl/ibs_pkg.sv
// ibs_pkg: shared types and constants for the incremental bounding sphere
// depends on nothing
package ibs_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned OFF_W = 33;
	localparam int unsigned SQ_W = 66;
	localparam int unsigned DIST_W = 34;
	localparam int unsigned RAD_W = 32;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SQ    = 8'b0000_0010,
		ST_ROOT  = 8'b0000_0100,
		ST_CMP   = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_UPD   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} ibs_state_t;
endpackage

### hw/rtl/ibs_divider.sv
// ibs_divider: restoring divider, one quotient bit per cycle
// depends on ibs_pkg
module ibs_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2*ibs_pkg::DIST_W-1:0]   num,
	input  logic [ibs_pkg::DIST_W-1:0]     den,
	output logic                           done,
	output logic [ibs_pkg::DIST_W-1:0]     quot
);
	import ibs_pkg::*;
	localparam int unsigned NW = 2 * DIST_W;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0]     num_q;
	logic [DIST_W:0]   rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DIST_W:0]   shifted;
	logic [DIST_W:0]   diff;

	// quotient fits DIST_W bits, so only the low bits of the shifting word are kept
	assign shifted = {rem_q[DIST_W-1:0], num_q[NW-1]};
	assign diff = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!diff[DIST_W]) begin
				rem_q <= diff;
				quot  <= {quot[DIST_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quot  <= {quot[DIST_W-2:0], 1'b0};
			end
		end
	end
endmodule

### hw/rtl/incremental_bounding_sphere.sv
// incremental_bounding_sphere: top level, sequencer and shared datapath
// depends on ibs_pkg and ibs_divider
//
// grows a bounding sphere one Q16.16 point per beat. a start or first point is taken
// as the centre and goes straight to the output state; a point checked against the
// sphere passes three squarings, a 34-step square root, a compare and the output
// state; one that grows the sphere runs, for each of the three axes, a multiply,
// a 68-step division and an update before the output state. the shared 34x34
// multiplier and the bit-serial divider serialise this work. the block takes one
// point at a time: stall is high while a point is in work and while the result
// beat waits, so the next point can be taken the cycle after the result is taken.
module incremental_bounding_sphere (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic        start_new,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic signed [31:0] center_z,
	output logic [31:0] sphere_radius,
	output logic        grew,
	output logic        saturated
);
	import ibs_pkg::*;

	ibs_state_t        state_q;
	logic signed [COORD_W-1:0] ctr_q [3];
	logic [RAD_W-1:0]  rad_q;
	logic              empty_q;
	logic signed [OFF_W-1:0] off_q [3];
	logic [SQ_W-1:0]   sum_q;
	logic [DIST_W-1:0] root_q;
	logic [DIST_W-1:0] half_q;
	logic [1:0]        axis_q;
	logic [5:0]        bit_q;

	// shared multiplier: squares in ST_SQ/ST_ROOT, |off|*half in ST_MUL
	logic [DIST_W-1:0] mul_a, mul_b;
	logic [2*DIST_W-1:0] mul_p;
	logic [DIST_W-1:0] trial;
	logic [OFF_W-1:0]  off_mag;
	logic              div_start, div_done;
	logic [DIST_W-1:0] div_q;
	logic [DIST_W:0]   rad_sum;
	logic signed [COORD_W+1:0] new_c;

	assign trial = root_q | (DIST_W'(1) << bit_q);
	assign off_mag = off_q[axis_q][OFF_W-1] ? OFF_W'(-off_q[axis_q]) : off_q[axis_q];

	always_comb begin
		mul_a = DIST_W'(off_mag);
		mul_b = DIST_W'(off_mag);
		unique case (state_q)
			ST_ROOT: begin
				mul_a = trial;
				mul_b = trial;
			end
			ST_MUL:  mul_b = half_q;
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign rad_sum = {3'b000, rad_q} + {1'b0, half_q};
	// step toward point with sign of offset; always between centre and point
	assign new_c = off_q[axis_q][OFF_W-1]
		? (COORD_W+2)'(ctr_q[axis_q]) - (COORD_W+2)'(signed'({2'b00, div_q}))
		: (COORD_W+2)'(ctr_q[axis_q]) + (COORD_W+2)'(signed'({2'b00, div_q}));

	// the divider loads |off|*half straight off the multiplier in ST_MUL
	assign div_start = (state_q == ST_MUL);

	ibs_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_p),
		.den    (root_q),
		.done   (div_done),
		.quot   (div_q)
	);

	// busy, or a result beat still waiting to be taken
	assign in_stall = (state_q != ST_IDLE) || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			empty_q   <= 1'b1;
			out_valid <= 1'b0;
			rad_q     <= '0;
			for (int i = 0; i < 3; i++) ctr_q[i] <= '0;
		end else begin
			if (state_q == ST_OUT) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && !in_stall) begin
					if (start_new || empty_q) begin
						// empty sphere: take the point as centre
						ctr_q[0] <= point_x;
						ctr_q[1] <= point_y;
						ctr_q[2] <= point_z;
						rad_q    <= '0;
						empty_q  <= 1'b0;
						grew     <= 1'b1;
						state_q  <= ST_OUT;
					end else begin
						off_q[0] <= OFF_W'(point_x) - OFF_W'(ctr_q[0]);
						off_q[1] <= OFF_W'(point_y) - OFF_W'(ctr_q[1]);
						off_q[2] <= OFF_W'(point_z) - OFF_W'(ctr_q[2]);
						sum_q    <= '0;
						axis_q   <= 2'd0;
						grew     <= 1'b0;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ: begin
					sum_q <= sum_q + SQ_W'(mul_p);
					if (axis_q == 2'd2) begin
						root_q  <= '0;
						bit_q   <= 6'(DIST_W - 1);
						state_q <= ST_ROOT;
					end else axis_q <= axis_q + 2'd1;
				end
				ST_ROOT: begin
					// one root bit per cycle, trial square compared at full width
					if (mul_p <= (2*DIST_W)'(sum_q)) root_q <= trial;
					if (bit_q == 6'd0) state_q <= ST_CMP;
					else bit_q <= bit_q - 6'd1;
				end
				ST_CMP: begin
					if (root_q > DIST_W'(rad_q)) begin
						half_q  <= (root_q - DIST_W'(rad_q)) >> 1;
						grew    <= 1'b1;
						axis_q  <= 2'd0;
						state_q <= ST_MUL;
					end else state_q <= ST_OUT;
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: if (div_done) state_q <= ST_UPD;
				ST_UPD: begin
					ctr_q[axis_q] <= COORD_W'(new_c);
					if (axis_q == 2'd2) begin
						rad_q   <= (|rad_sum[DIST_W:RAD_W]) ? '1 : rad_sum[RAD_W-1:0];
						state_q <= ST_OUT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign center_x = ctr_q[0];
	assign center_y = ctr_q[1];
	assign center_z = ctr_q[2];
	assign sphere_radius = rad_q;
	assign saturated = (rad_q == '1);
endmodule

### hw/rtl/ibs_checker.sv
// ibs_checker: port-level checks for incremental_bounding_sphere
// depends on incremental_bounding_sphere ports only
module ibs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] sphere_radius,
	input logic        grew,
	input logic        saturated
);
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (saturated == (sphere_radius == 32'hFFFF_FFFF))) else $error("sat");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(sphere_radius) && $stable(grew))
		else $error("hold");
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("block");
endmodule

bind incremental_bounding_sphere ibs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .sphere_radius(sphere_radius),
	.grew(grew), .saturated(saturated)
);

### tb/sv/incremental_bounding_sphere_tb.sv
// incremental_bounding_sphere_tb: self-checking bench for the bounding sphere block
// drives points through a valid/stall channel and checks every result beat against
// a local predictor; depends on ibs_pkg and the block's rtl
module incremental_bounding_sphere_tb;
	import ibs_pkg::*;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               fresh;
	} point_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [31:0]        rad;
		logic               grew;
		logic               sat;
	} sphere_t;

	// directed row: point plus an optional hand-typed expectation
	typedef struct packed {
		point_t  pt;
		logic    typed;
		sphere_t want;
	} row_t;

	localparam int N_RANDOM = 2000;
	localparam int IDLE_PCT = 27;
	localparam int WATCHDOG = 4000;
	localparam int DRAIN_CYCLES = 600;
	localparam logic [31:0] RMAX = 32'hFFFF_FFFF;
	localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;

	logic clk, arst_n;
	logic in_valid, in_stall, start_new, out_valid, out_stall;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [31:0] center_x, center_y, center_z;
	logic [31:0] sphere_radius;
	logic grew, saturated;

	incremental_bounding_sphere dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.start_new(start_new),
		.out_valid(out_valid), .out_stall(out_stall),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.sphere_radius(sphere_radius), .grew(grew), .saturated(saturated)
	);

	// predictor state, mirrors the block's running sphere
	logic signed [31:0] sph_cx, sph_cy, sph_cz;
	logic [31:0] sph_rad;
	logic sph_empty;

	// hand-typed expectation for the beat being offered, if any
	logic cur_typed;
	sphere_t cur_want;

	sphere_t pending_spheres[$];
	int errors, n_in, n_out, n_grew, n_sat, idle_cycles;
	bit quiet_rx, hold_rx;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// floor square root of a 66-bit sum, 34-bit result
	function automatic logic [33:0] floor_root(logic [65:0] s);
		logic [33:0] r;
		logic [33:0] c;
		logic [67:0] sq;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			sq = c * c;
			if (sq <= {2'b0, s})
				r = c;
		end
		return r;
	endfunction

	// one axis of the centre move: truncated |off|*half/d_len with the sign of off
	function automatic logic signed [31:0] shift_axis(logic signed [31:0] c,
			logic signed [32:0] off, logic [33:0] half, logic [33:0] d_len);
		logic [32:0] m;
		logic [66:0] prod, step;
		logic signed [68:0] n;
		m = off[32] ? 33'(-off) : 33'(off);
		prod = m * half;
		step = prod / d_len;
		if (off[32])
			n = 69'(c) - $signed({2'b0, step});
		else
			n = 69'(c) + $signed({2'b0, step});
		if (n > 69'(SMAX)) return SMAX;
		if (n < 69'(SMIN)) return SMIN;
		return n[31:0];
	endfunction

	// merge one point into the predicted sphere
	function automatic sphere_t merge_point(point_t p);
		sphere_t r;
		logic signed [32:0] ox, oy, oz;
		logic [32:0] ax, ay, az;
		logic [65:0] sum;
		logic [33:0] d_len, half;
		logic [34:0] nr;
		r.grew = 0;
		if (p.fresh)
			sph_empty = 1;
		if (sph_empty) begin
			sph_cx = p.px; sph_cy = p.py; sph_cz = p.pz;
			sph_rad = 0;
			sph_empty = 0;
			r.grew = 1;
		end else begin
			ox = 33'(p.px) - 33'(sph_cx);
			oy = 33'(p.py) - 33'(sph_cy);
			oz = 33'(p.pz) - 33'(sph_cz);
			ax = ox[32] ? 33'(-ox) : 33'(ox);
			ay = oy[32] ? 33'(-oy) : 33'(oy);
			az = oz[32] ? 33'(-oz) : 33'(oz);
			sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
			d_len = floor_root(sum);
			if (d_len > {2'b0, sph_rad}) begin
				half = (d_len - {2'b0, sph_rad}) >> 1;
				nr = {3'b0, sph_rad} + {1'b0, half};
				r.grew = 1;
				sph_rad = (nr > {3'b0, RMAX}) ? RMAX : nr[31:0];
				sph_cx = shift_axis(sph_cx, ox, half, d_len);
				sph_cy = shift_axis(sph_cy, oy, half, d_len);
				sph_cz = shift_axis(sph_cz, oz, half, d_len);
			end
		end
		r.cx = sph_cx; r.cy = sph_cy; r.cz = sph_cz;
		r.rad = sph_rad;
		r.sat = (sph_rad == RMAX);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %h want %h", n_out, what, got, want);
		errors++;
	endtask

	// random coordinate: mostly small, some near the extremes
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? SMAX - $urandom_range(255) : SMIN + $urandom_range(255);
			2, 3: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
			default: return $signed($urandom_range(32'h0007_FFFF)) - 32'sh0004_0000;
		endcase
	endfunction

	// sends one point beat, idling at random before it outside the quiet stretch; valid
	// stays up after the beat until the next call idles or offers a new point
	task automatic send_point(point_t p);
		if (!quiet_rx)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 0;
				@(negedge clk);
			end
		in_valid <= 1;
		point_x <= p.px; point_y <= p.py; point_z <= p.pz;
		start_new <= p.fresh;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// accepted input beats feed the predictor; typed rows carry their own expectation
	always @(posedge clk) begin
		sphere_t w;
		if (arst_n && in_valid && !in_stall) begin
			w = merge_point('{point_x, point_y, point_z, start_new});
			pending_spheres.push_back(cur_typed ? cur_want : w);
			n_in++;
		end
	end

	// accepted result beats are checked against the oldest expectation
	always @(posedge clk) begin
		sphere_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_spheres.size() == 0) begin
				$display("unexpected result beat %0d", n_out);
				errors++;
			end else begin
				w = pending_spheres.pop_front();
				if (center_x !== w.cx) report_mismatch("center_x", center_x, w.cx);
				if (center_y !== w.cy) report_mismatch("center_y", center_y, w.cy);
				if (center_z !== w.cz) report_mismatch("center_z", center_z, w.cz);
				if (sphere_radius !== w.rad) report_mismatch("radius", sphere_radius, w.rad);
				if (grew !== w.grew) report_mismatch("grew", grew, w.grew);
				if (saturated !== w.sat) report_mismatch("saturated", saturated, w.sat);
				if (w.grew) n_grew++;
				if (w.sat) n_sat++;
			end
			n_out++;
		end
	end

	// receiver stall: random, quiet stretch, and one long hold-off
	always @(negedge clk) begin
		if (hold_rx || !arst_n)
			out_stall <= 1;
		else if (quiet_rx)
			out_stall <= 0;
		else
			out_stall <= ($urandom_range(99) < IDLE_PCT);
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no progress, %0d results pending", pending_spheres.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering points
	initial begin
		hold_rx = 0;
		wait (n_in == 40);
		@(negedge clk);
		hold_rx = 1;
		repeat (800) @(negedge clk);
		hold_rx = 0;
	end

	row_t rows[$];
	point_t p;

	initial begin
		errors = 0; n_in = 0; n_out = 0; n_grew = 0; n_sat = 0;
		quiet_rx = 0;
		cur_typed = 0; cur_want = '0;
		in_valid = 0; point_x = 0; point_y = 0; point_z = 0; start_new = 0;
		sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_rad = 0; sph_empty = 1;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// first point after reset starts the sphere even without the flag
		rows.push_back('{'{32'sd65536, -32'sd65536, 32'sd0, 1'b0}, 1'b1,
			'{32'sd65536, -32'sd65536, 32'sd0, 32'd0, 1'b1, 1'b0}});
		// same point again: inside, nothing changes
		rows.push_back('{'{32'sd65536, -32'sd65536, 32'sd0, 1'b0}, 1'b1,
			'{32'sd65536, -32'sd65536, 32'sd0, 32'd0, 1'b0, 1'b0}});
		// one lsb away: just outside, half is zero
		rows.push_back('{'{32'sd65537, -32'sd65536, 32'sd0, 1'b0}, 1'b0, '0});
		rows.push_back('{'{32'sd65538, -32'sd65536, 32'sd0, 1'b0}, 1'b0, '0});
		rows.push_back('{'{-32'sd300000, 32'sd70000, 32'sd12345, 1'b0}, 1'b0, '0});
		// restart on the most negative corner
		rows.push_back('{'{SMIN, SMIN, SMIN, 1'b1}, 1'b1,
			'{SMIN, SMIN, SMIN, 32'd0, 1'b1, 1'b0}});
		// opposite corner: the sphere grows, the radius stays below saturation
		rows.push_back('{'{SMAX, SMAX, SMAX, 1'b0}, 1'b0, '0});
		rows.push_back('{'{SMIN, SMAX, SMIN, 1'b0}, 1'b0, '0});
		rows.push_back('{'{SMAX, SMIN, SMAX, 1'b0}, 1'b0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 1'b0}, 1'b0, '0});
		rows.push_back('{'{SMAX, SMAX, SMAX, 1'b1}, 1'b1,
			'{SMAX, SMAX, SMAX, 32'd0, 1'b1, 1'b0}});
		rows.push_back('{'{SMIN, 32'sd0, 32'sd0, 1'b0}, 1'b0, '0});
		rows.push_back('{'{-32'sd1, -32'sd1, -32'sd1, 1'b1}, 1'b1,
			'{-32'sd1, -32'sd1, -32'sd1, 32'd0, 1'b1, 1'b0}});
		rows.push_back('{'{32'sd1, -32'sd1, -32'sd1, 1'b0}, 1'b0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 32'sh0010_0000, 1'b0}, 1'b0, '0});
		rows.push_back('{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b0}, 1'b0, '0});

		foreach (rows[i]) begin
			cur_typed = rows[i].typed;
			cur_want = rows[i].want;
			send_point(rows[i].pt);
		end
		cur_typed = 0;

		// random part: runs of growing sets with restarts, a quiet stretch in the middle
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_rx = (i >= 600 && i < 800);
			p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
			p.fresh = ($urandom_range(19) == 0);
			send_point(p);
		end
		quiet_rx = 0;
		in_valid <= 0;

		while (pending_spheres.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d points in, %0d results checked, %0d grew the sphere, %0d saturated",
			n_in, n_out, n_grew, n_sat);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
